/* hdl/dls_pkg.sv */
// Shared constants and types for the dimmer level stepper.
`default_nettype none
package dls_pkg;

  // table geometry
  localparam int LEVEL_COUNT = 256;
  localparam int IDX_W       = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int LVL_W       = 8;
  localparam int DUTY_W      = 8;
  // read address holds any level plus one, so the entry past the end is reachable
  localparam int ADDR_W      = LVL_W + 1;

  // event codes
  localparam logic [2:0] OP_TOGGLE  = 3'd0;
  localparam logic [2:0] OP_BRIGHT  = 3'd1;
  localparam logic [2:0] OP_DIM     = 3'd2;
  localparam logic [2:0] OP_SET     = 3'd3;
  localparam logic [2:0] OP_WRITE   = 3'd4;
  localparam logic [2:0] OP_REAPPLY = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_MAX   = 2'd2;
  localparam logic [1:0] ST_MIN   = 2'd3;

  // table write request
  typedef struct packed {
    logic              en;
    logic [LVL_W-1:0]  addr;
    logic [DUTY_W-1:0] data;
  } tbl_wr_t;

  // one result beat
  typedef struct packed {
    logic              light_on;
    logic [LVL_W-1:0]  level_now;
    logic [DUTY_W-1:0] duty_now;
    logic [1:0]        status;
  } rsp_t;

endpackage
`default_nettype wire

/* hdl/dls_if.sv */
// Channel interfaces: command events, results and the configuration write.
`default_nettype none
interface dls_cmd_if
  import dls_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic              want_on;
  logic [LVL_W-1:0]  want_level;
  logic              duty_given;
  logic [DUTY_W-1:0] want_duty;
  logic [LVL_W-1:0]  entry_index;
  logic [DUTY_W-1:0] entry_duty;

  modport source (output valid, opcode, want_on, want_level, duty_given, want_duty,
                  entry_index, entry_duty, input ready);
  modport sink   (input valid, opcode, want_on, want_level, duty_given, want_duty,
                  entry_index, entry_duty, output ready);
endinterface

interface dls_rsp_if
  import dls_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              light_on;
  logic [LVL_W-1:0]  level_now;
  logic [DUTY_W-1:0] duty_now;
  logic [1:0]        status;

  modport source (output valid, light_on, level_now, duty_now, status, input ready);
  modport sink   (input valid, light_on, level_now, duty_now, status, output ready);
endinterface

interface dls_cfg_if
  import dls_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* hdl/dls_table_ram.sv */
// Level table: synchronous RAM with per-entry valid bits cleared by reset.
`default_nettype none
module dls_table_ram
  import dls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DUTY_W-1:0] rd_data,
  input  wire tbl_wr_t           wr
);

  logic [DUTY_W-1:0]      mem [LEVEL_COUNT];
  logic [LEVEL_COUNT-1:0] valid;
  logic                   rd_in_range;
  logic                   wr_in_range;

  assign rd_in_range = rd_addr < ADDR_W'(LEVEL_COUNT);
  assign wr_in_range = {1'b0, wr.addr} < ADDR_W'(LEVEL_COUNT);

  // write port; writes past the end are dropped
  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr.addr[IDX_W-1:0]] <= wr.data;
    end
  end

  // valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en && wr_in_range) begin
      valid[wr.addr[IDX_W-1:0]] <= 1'b1;
    end
  end

  // registered read; out of range reads zero
  always_ff @(posedge clk) begin
    if (rd_in_range && valid[rd_addr[IDX_W-1:0]]) begin
      rd_data <= mem[rd_addr[IDX_W-1:0]];
    end else begin
      rd_data <= '0;
    end
  end

endmodule
`default_nettype wire

/* hdl/dls_ctrl.sv */
// Event sequencer: holds the light state, reads the table and walks it for snaps.
`default_nettype none
module dls_ctrl
  import dls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  dls_cmd_if.sink                cmd,
  input  wire logic [LVL_W-1:0]  off_level,
  input  wire logic              res_free,
  output logic                   res_load,
  output rsp_t                   res_data,
  output logic      [ADDR_W-1:0] rd_addr,
  input  wire logic [DUTY_W-1:0] rd_data,
  output tbl_wr_t                tbl_wr
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ISSUE   = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_OFFRD   = 3'd4;
  localparam logic [2:0] S_OFFWB   = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0] state;

  // captured event
  logic [2:0]        op;
  logic              want_on;
  logic [LVL_W-1:0]  want_level;
  logic              duty_given;
  logic [DUTY_W-1:0] want_duty;
  logic [LVL_W-1:0]  entry_index;
  logic [DUTY_W-1:0] entry_duty;

  // light state
  logic              on_flag;
  logic [LVL_W-1:0]  level;
  logic [DUTY_W-1:0] duty;
  logic [1:0]        status;

  // table walk
  logic [ADDR_W-1:0] scan_ptr;
  logic [LVL_W-1:0]  scan_prev;
  logic              scan_have;
  logic              found;
  logic [LVL_W-1:0]  found_level;
  logic [DUTY_W-1:0] found_duty;

  logic [ADDR_W-1:0] issue_addr;
  logic              scan_stop;

  assign cmd.ready = (state == S_IDLE);

  // first table read of each event
  always_comb begin
    unique case (op)
      OP_BRIGHT:  issue_addr = on_flag ? ({1'b0, level} + ADDR_W'(1)) : '0;
      OP_DIM:     issue_addr = (level == '0) ? {1'b0, off_level}
                                             : {1'b0, level - LVL_W'(1)};
      OP_SET:     issue_addr = {1'b0, want_level};
      OP_REAPPLY: issue_addr = {1'b0, level};
      default:    issue_addr = '0;
    endcase
  end

  always_comb begin
    unique case (state)
      S_ISSUE: rd_addr = issue_addr;
      S_SCAN:  rd_addr = scan_ptr;
      S_OFFRD: rd_addr = {1'b0, off_level};
      default: rd_addr = '0;
    endcase
  end

  assign scan_stop = (rd_data == '0) || (rd_data > duty);

  assign tbl_wr.en   = (state == S_ISSUE) && (op == OP_WRITE);
  assign tbl_wr.addr = entry_index;
  assign tbl_wr.data = entry_duty;

  assign res_load           = (state == S_DONE) && res_free;
  assign res_data.light_on  = on_flag;
  assign res_data.level_now = level;
  assign res_data.duty_now  = duty;
  assign res_data.status    = status;

  // event capture
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op          <= cmd.opcode;
      want_on     <= cmd.want_on;
      want_level  <= cmd.want_level;
      duty_given  <= cmd.duty_given;
      want_duty   <= cmd.want_duty;
      entry_index <= cmd.entry_index;
      entry_duty  <= cmd.entry_duty;
    end
  end

  // sequencer and light state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      on_flag   <= 1'b0;
      level     <= '0;
      duty      <= '0;
      status    <= ST_OK;
      scan_ptr  <= '0;
      scan_have <= 1'b0;
      found     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            status <= ST_OK;
            state  <= S_ISSUE;
          end
        end

        S_ISSUE: begin
          state <= S_RESOLVE;
          unique case (op)
            OP_TOGGLE: begin
              on_flag <= ~on_flag;
              state   <= S_DONE;
            end
            OP_DIM: begin
              if (!on_flag) begin
                status <= ST_MIN;
                state  <= S_DONE;
              end
            end
            OP_SET: begin
              // a given duty is taken first, then snapped
              if (duty_given) begin
                on_flag <= want_on;
                level   <= want_level;
                duty    <= want_duty;
              end
            end
            OP_BRIGHT, OP_REAPPLY: ;
            default: state <= S_DONE;
          endcase
        end

        S_RESOLVE: begin
          state <= S_DONE;
          unique case (op)
            OP_BRIGHT: begin
              if (!on_flag) begin
                on_flag <= 1'b1;
                level   <= '0;
                duty    <= rd_data;
              end else if (rd_data == '0) begin
                status <= ST_MAX;
              end else begin
                level <= level + LVL_W'(1);
                duty  <= rd_data;
              end
            end
            OP_DIM: begin
              if (level == '0) begin
                on_flag <= 1'b0;
                level   <= off_level;
              end else begin
                level <= level - LVL_W'(1);
              end
              duty <= rd_data;
            end
            default: begin
              if (op == OP_SET && !duty_given) begin
                if (rd_data == '0) begin
                  status <= ST_RANGE;
                end else begin
                  on_flag <= want_on;
                  level   <= want_level;
                  duty    <= rd_data;
                end
              end else if (duty != rd_data) begin
                // snap: walk the table from entry 0
                scan_ptr  <= '0;
                scan_have <= 1'b0;
                found     <= 1'b0;
                state     <= S_SCAN;
              end
            end
          endcase
        end

        S_SCAN: begin
          // read data belongs to scan_prev, one behind the issued pointer
          if (scan_have && scan_stop) begin
            if (found) begin
              level <= found_level;
              duty  <= found_duty;
              state <= S_DONE;
            end else begin
              on_flag <= 1'b0;
              state   <= S_OFFRD;
            end
          end else begin
            if (scan_have) begin
              found <= 1'b1;
            end
            scan_ptr  <= scan_ptr + ADDR_W'(1);
            scan_have <= 1'b1;
          end
        end

        S_OFFRD: state <= S_OFFWB;

        S_OFFWB: begin
          level <= off_level;
          duty  <= rd_data;
          state <= S_DONE;
        end

        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // walk bookkeeping
  always_ff @(posedge clk) begin
    if (state == S_SCAN && !(scan_have && scan_stop)) begin
      scan_prev <= scan_ptr[LVL_W-1:0];
      if (scan_have) begin
        found_level <= scan_prev;
        found_duty  <= rd_data;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/dimmer_level_stepper.sv */
// Top level: off level register, result register, sequencer and level table.
// Path from command beat to result beat: toggle, table write and rejected dimmer
// pass IDLE, ISSUE, DONE; brighter, dimmer, plain set state and a matching snap add
// RESOLVE; a walking snap adds SCAN, one table entry per cycle through the single
// RAM read port, then OFFRD, OFFWB if it turns the light off. One event at a time.
// Reset (synchronous, rst high): light off, level 0, duty 0, off level 0, all
// table entries read as zero from the cycle after reset; no clearing pass.
`default_nettype none
module dimmer_level_stepper
  import dls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  dls_cmd_if.sink   cmd,
  dls_rsp_if.source rsp,
  dls_cfg_if.sink   cfg
);

  logic [LVL_W-1:0]  off_level;
  logic              res_free;
  logic              res_load;
  rsp_t              res_data;
  rsp_t              res_q;
  logic              res_valid;
  logic [ADDR_W-1:0] rd_addr;
  logic [DUTY_W-1:0] rd_data;
  tbl_wr_t           tbl_wr;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_level <= '0;
    end else if (cfg.valid) begin
      off_level <= cfg.data;
    end
  end

  // result register: frees up on the beat that takes it
  assign res_free = !res_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res_data;
    end
  end

  assign rsp.valid     = res_valid;
  assign rsp.light_on  = res_q.light_on;
  assign rsp.level_now = res_q.level_now;
  assign rsp.duty_now  = res_q.duty_now;
  assign rsp.status    = res_q.status;

  dls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .off_level (off_level),
    .res_free  (res_free),
    .res_load  (res_load),
    .res_data  (res_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .tbl_wr    (tbl_wr)
  );

  dls_table_ram u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (tbl_wr)
  );

endmodule
`default_nettype wire
